FILE: design/ebc_pkg.sv
// Shared types and constants for the eight-bit instruction stepper.
package ebc_pkg;

	localparam logic [1:0] ACT_STEP  = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_RESET = 2'd3;

	localparam logic [15:0] PC_RESET   = 16'h0010;
	localparam logic [15:0] VEC_LO     = 16'hfffc;
	localparam logic [15:0] VEC_HI     = 16'hfffd;
	localparam logic [7:0]  STACK_PAGE = 8'h01;

	localparam logic [7:0] OP_ORA_IMM = 8'h09;
	localparam logic [7:0] OP_AND_IMM = 8'h29;
	localparam logic [7:0] OP_LDA_IMM = 8'hA9;
	localparam logic [7:0] OP_LDA_ABS = 8'hAD;
	localparam logic [7:0] OP_LDA_ABX = 8'hBD;
	localparam logic [7:0] OP_LDX_IMM = 8'hA2;
	localparam logic [7:0] OP_LDY_IMM = 8'hA0;
	localparam logic [7:0] OP_STA_ZP  = 8'h85;
	localparam logic [7:0] OP_STA_ABS = 8'h8D;
	localparam logic [7:0] OP_STA_ABY = 8'h99;
	localparam logic [7:0] OP_STA_IZY = 8'h91;
	localparam logic [7:0] OP_STX_ZP  = 8'h86;
	localparam logic [7:0] OP_BIT_ABS = 8'h2C;
	localparam logic [7:0] OP_INC_ABS = 8'hEE;
	localparam logic [7:0] OP_CMP_IMM = 8'hC9;
	localparam logic [7:0] OP_CPX_IMM = 8'hE0;
	localparam logic [7:0] OP_CPY_IMM = 8'hC0;
	localparam logic [7:0] OP_DEX     = 8'hCA;
	localparam logic [7:0] OP_DEY     = 8'h88;
	localparam logic [7:0] OP_INY     = 8'hC8;
	localparam logic [7:0] OP_TXA     = 8'h8A;
	localparam logic [7:0] OP_TXS     = 8'h9A;
	localparam logic [7:0] OP_SEI     = 8'h78;
	localparam logic [7:0] OP_CLD     = 8'hD8;
	localparam logic [7:0] OP_JMP     = 8'h4C;
	localparam logic [7:0] OP_JSR     = 8'h20;
	localparam logic [7:0] OP_RTS     = 8'h60;
	localparam logic [7:0] OP_BPL     = 8'h10;
	localparam logic [7:0] OP_BCS     = 8'hB0;
	localparam logic [7:0] OP_BNE     = 8'hD0;

	// Memory address source selected by the controller.
	typedef enum logic [3:0] {
		AS_PC, AS_PC1, AS_PC2, AS_ABS, AS_IDX, AS_VEC, AS_HOST, AS_STACK, AS_ZP, AS_ZP1
	} addr_sel_t;

	// Latch targets for the returning read byte.
	typedef enum logic [2:0] {
		LD_NONE, LD_OP, LD_B0, LD_B1, LD_T0, LD_T1
	} load_sel_t;

	// Stack pointer updates.
	typedef enum logic [1:0] { SP_KEEP, SP_DEC, SP_INC } sp_op_t;

	typedef enum logic [2:0] {
		WD_ACC, WD_X, WD_PCH, WD_PCL, WD_INC, WD_HOST
	} wdata_sel_t;

	typedef enum logic [1:0] { IX_X, IX_Y, IX_PTR } idx_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		addr_sel_t  asel;
		idx_sel_t   isel;
		logic       rd;
		logic       wr;
		wdata_sel_t wsel;
		load_sel_t  ld;
		sp_op_t     sp;
		logic       exec;
		logic       set_vec_pc;
		logic       capture_rd;
		logic       start;
	} ebc_cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic [7:0] opcode;
	} ebc_stat_t;

endpackage

FILE: design/eight_bit_cpu_instruction_step_top.sv
// Top level of the eight-bit instruction stepper.
// Each accepted word is one action: a step executes the instruction at PC, a load writes one
// byte, a read returns one byte and a reset loads PC from the vector at FFFC/FFFD. The block
// handles one word at a time; all accesses go through one single-port memory with a registered
// read. A step reads the opcode and two operands, waits for the last operand, makes up to three
// data or stack accesses, executes and outputs; a load writes, a read reads and captures the
// byte and a reset reads both vector bytes, waits and loads PC. Output holds on any out_stall.
// The memory holds no reset value; read only bytes that were written.
module eight_bit_cpu_instruction_step_top #(
	parameter int MEM_DEPTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [15:0] mem_address,
	input  logic [7:0]  mem_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pc_value,
	output logic [7:0]  acc_value,
	output logic [7:0]  x_value,
	output logic [7:0]  y_value,
	output logic [7:0]  sp_value,
	output logic [7:0]  flags_value,
	output logic [2:0]  cycle_count,
	output logic [7:0]  read_byte,
	output logic        unsupported
);

	ebc_pkg::ebc_cmd_t  cmd;
	ebc_pkg::ebc_stat_t stat;

	ebc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Host fields are only used in the accepting cycle.
	ebc_datapath #(.MEM_DEPTH(MEM_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.host_addr (mem_address),
		.host_data (mem_data),
		.pc_q      (pc_value),
		.a_q       (acc_value),
		.x_q       (x_value),
		.y_q       (y_value),
		.sp_q      (sp_value),
		.p_q       (flags_value),
		.cyc_q     (cycle_count),
		.rb_q      (read_byte),
		.unsup_q   (unsupported)
	);

endmodule

FILE: design/ebc_ram.sv
// Generic single-port byte RAM with registered read data.
module ebc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

FILE: design/ebc_datapath.sv
// Register file, address generation, execute logic and memory of the stepper.
module ebc_datapath #(
	parameter int MEM_DEPTH = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ebc_pkg::ebc_cmd_t cmd,
	output ebc_pkg::ebc_stat_t stat,
	input  logic [15:0]       host_addr,
	input  logic [7:0]        host_data,
	output logic [15:0]       pc_q,
	output logic [7:0]        a_q,
	output logic [7:0]        x_q,
	output logic [7:0]        y_q,
	output logic [7:0]        sp_q,
	output logic [7:0]        p_q,
	output logic [2:0]        cyc_q,
	output logic [7:0]        rb_q,
	output logic              unsup_q
);

	localparam int AW = $clog2(MEM_DEPTH);

	logic [7:0]  op_q, b0_q, b1_q, t0_q, t1_q;
	logic [7:0]  rdata;
	logic [15:0] addr;
	logic [15:0] abs16, ptr16, idx_addr, next2, dest;
	logic [7:0]  wdata, idx;
	logic        ld_pend_q;
	ebc_pkg::load_sel_t ld_q;

	assign abs16 = {b1_q, b0_q};
	assign ptr16 = {t1_q, t0_q};
	assign stat.opcode = op_q;

	always_comb begin
		case (cmd.isel)
			ebc_pkg::IX_Y: idx = y_q;
			default:       idx = x_q;
		endcase
	end
	assign idx_addr = (cmd.isel == ebc_pkg::IX_PTR) ? ptr16 + {8'h00, y_q}
		: abs16 + {8'h00, idx};

	always_comb begin
		case (cmd.asel)
			ebc_pkg::AS_PC:    addr = pc_q;
			ebc_pkg::AS_PC1:   addr = pc_q + 16'd1;
			ebc_pkg::AS_PC2:   addr = pc_q + 16'd2;
			ebc_pkg::AS_ABS:   addr = abs16;
			ebc_pkg::AS_IDX:   addr = idx_addr;
			ebc_pkg::AS_VEC:   addr = (cmd.ld == ebc_pkg::LD_T1) ? ebc_pkg::VEC_HI
				: ebc_pkg::VEC_LO;
			ebc_pkg::AS_HOST:  addr = host_addr;
			ebc_pkg::AS_STACK: addr = {ebc_pkg::STACK_PAGE,
				(cmd.sp == ebc_pkg::SP_INC) ? sp_q + 8'd1 : sp_q};
			ebc_pkg::AS_ZP:    addr = {8'h00, b0_q};
			// Zero-page pointer high byte wraps within page zero.
			ebc_pkg::AS_ZP1:   addr = {8'h00, b0_q + 8'd1};
			default:           addr = pc_q;
		endcase
	end

	always_comb begin
		case (cmd.wsel)
			ebc_pkg::WD_ACC:  wdata = a_q;
			ebc_pkg::WD_X:    wdata = x_q;
			ebc_pkg::WD_PCH:  wdata = next2[15:8];
			ebc_pkg::WD_PCL:  wdata = next2[7:0];
			ebc_pkg::WD_INC:  wdata = t0_q + 8'd1;
			ebc_pkg::WD_HOST: wdata = host_data;
			default:          wdata = a_q;
		endcase
	end

	ebc_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (cmd.wr),
		.re    (cmd.rd),
		.addr  (addr[AW-1:0]),
		.wdata (wdata),
		.rdata (rdata)
	);

	// Read data arrives in the cycle after the request; the target is remembered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_q      <= ebc_pkg::LD_NONE;
			ld_pend_q <= 1'b0;
		end else begin
			ld_q      <= cmd.ld;
			ld_pend_q <= cmd.rd;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_pend_q) begin
			case (ld_q)
				ebc_pkg::LD_OP: op_q <= rdata;
				ebc_pkg::LD_B0: b0_q <= rdata;
				ebc_pkg::LD_B1: b1_q <= rdata;
				ebc_pkg::LD_T0: t0_q <= rdata;
				ebc_pkg::LD_T1: t1_q <= rdata;
				default: ;
			endcase
		end
	end

	assign next2 = pc_q + 16'd2;
	assign dest  = next2 + {{8{b0_q[7]}}, b0_q};

	logic [7:0] diff;
	logic [7:0] cmp_reg;
	always_comb begin
		case (op_q)
			ebc_pkg::OP_CPX_IMM: cmp_reg = x_q;
			ebc_pkg::OP_CPY_IMM: cmp_reg = y_q;
			default:             cmp_reg = a_q;
		endcase
	end
	assign diff = cmp_reg - b0_q;

	function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
		logic [7:0] r;
		r    = p;
		r[7] = v[7];
		r[1] = (v == 8'h00);
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= ebc_pkg::PC_RESET;
			a_q     <= '0;
			x_q     <= '0;
			y_q     <= '0;
			sp_q    <= '0;
			p_q     <= '0;
			cyc_q   <= '0;
			rb_q    <= '0;
			unsup_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				cyc_q   <= '0;
				rb_q    <= '0;
				unsup_q <= 1'b0;
			end
			if (cmd.sp == ebc_pkg::SP_DEC) sp_q <= sp_q - 8'd1;
			else if (cmd.sp == ebc_pkg::SP_INC) sp_q <= sp_q + 8'd1;
			if (cmd.capture_rd) rb_q <= rdata;
			if (cmd.set_vec_pc) pc_q <= ptr16;
			if (cmd.exec) begin
				unique case (op_q)
					ebc_pkg::OP_ORA_IMM: begin
						a_q <= a_q | b0_q; p_q <= nz(p_q, a_q | b0_q);
						pc_q <= next2; cyc_q <= 3'd2;
					end
					ebc_pkg::OP_AND_IMM: begin
						a_q <= a_q & b0_q; p_q <= nz(p_q, a_q & b0_q);
						pc_q <= next2; cyc_q <= 3'd2;
					end
					ebc_pkg::OP_LDA_IMM: begin
						a_q <= b0_q; p_q <= nz(p_q, b0_q); pc_q <= next2; cyc_q <= 3'd2;
					end
					ebc_pkg::OP_LDA_ABS: begin
						a_q <= t0_q; p_q <= nz(p_q, t0_q); pc_q <= pc_q + 16'd3;
						cyc_q <= 3'd4;
					end
					ebc_pkg::OP_LDA_ABX: begin
						a_q <= t0_q; p_q <= nz(p_q, t0_q); pc_q <= pc_q + 16'd3;
						cyc_q <= ((abs16 + {8'h00, x_q}) >> 8) != (abs16 >> 8) ? 3'd5 : 3'd4;
					end
					ebc_pkg::OP_LDX_IMM: begin
						x_q <= b0_q; p_q <= nz(p_q, b0_q); pc_q <= next2; cyc_q <= 3'd2;
					end
					ebc_pkg::OP_LDY_IMM: begin
						y_q <= b0_q; p_q <= nz(p_q, b0_q); pc_q <= next2; cyc_q <= 3'd2;
					end
					ebc_pkg::OP_STA_ZP, ebc_pkg::OP_STX_ZP: begin
						pc_q <= next2; cyc_q <= 3'd3;
					end
					ebc_pkg::OP_STA_ABS: begin pc_q <= pc_q + 16'd3; cyc_q <= 3'd4; end
					ebc_pkg::OP_STA_ABY: begin pc_q <= pc_q + 16'd3; cyc_q <= 3'd5; end
					ebc_pkg::OP_STA_IZY: begin pc_q <= next2; cyc_q <= 3'd6; end
					ebc_pkg::OP_BIT_ABS: begin
						p_q <= {t0_q[7:6], p_q[5:2], (a_q & t0_q) == 8'h00, p_q[0]};
						pc_q <= pc_q + 16'd3; cyc_q <= 3'd4;
					end
					ebc_pkg::OP_INC_ABS: begin
						p_q <= nz(p_q, t0_q + 8'd1); pc_q <= pc_q + 16'd3; cyc_q <= 3'd6;
					end
					ebc_pkg::OP_CMP_IMM, ebc_pkg::OP_CPX_IMM, ebc_pkg::OP_CPY_IMM: begin
						p_q <= {diff[7], p_q[6:2], diff == 8'h00, cmp_reg >= b0_q};
						pc_q <= next2; cyc_q <= 3'd2;
					end
					ebc_pkg::OP_DEX: begin
						x_q <= x_q - 8'd1; p_q <= nz(p_q, x_q - 8'd1);
						pc_q <= pc_q + 16'd1; cyc_q <= 3'd2;
					end
					ebc_pkg::OP_DEY: begin
						y_q <= y_q - 8'd1; p_q <= nz(p_q, y_q - 8'd1);
						pc_q <= pc_q + 16'd1; cyc_q <= 3'd2;
					end
					ebc_pkg::OP_INY: begin
						y_q <= y_q + 8'd1; p_q <= nz(p_q, y_q + 8'd1);
						pc_q <= pc_q + 16'd1; cyc_q <= 3'd2;
					end
					ebc_pkg::OP_TXA: begin
						a_q <= x_q; p_q <= nz(p_q, x_q); pc_q <= pc_q + 16'd1; cyc_q <= 3'd2;
					end
					ebc_pkg::OP_TXS: begin
						sp_q <= x_q; pc_q <= pc_q + 16'd1; cyc_q <= 3'd2;
					end
					ebc_pkg::OP_SEI: begin
						p_q[2] <= 1'b1; pc_q <= pc_q + 16'd1; cyc_q <= 3'd2;
					end
					ebc_pkg::OP_CLD: begin
						p_q[3] <= 1'b0; pc_q <= pc_q + 16'd1; cyc_q <= 3'd2;
					end
					ebc_pkg::OP_JMP: begin pc_q <= abs16; cyc_q <= 3'd3; end
					ebc_pkg::OP_JSR: begin pc_q <= abs16; cyc_q <= 3'd6; end
					ebc_pkg::OP_RTS: begin pc_q <= ptr16 + 16'd1; cyc_q <= 3'd6; end
					ebc_pkg::OP_BPL, ebc_pkg::OP_BCS, ebc_pkg::OP_BNE: begin
						if ((op_q == ebc_pkg::OP_BPL && !p_q[7]) ||
						    (op_q == ebc_pkg::OP_BCS && p_q[0]) ||
						    (op_q == ebc_pkg::OP_BNE && !p_q[1])) begin
							pc_q  <= dest;
							cyc_q <= (dest[15:8] != next2[15:8]) ? 3'd4 : 3'd3;
						end else begin
							pc_q  <= next2;
							cyc_q <= 3'd2;
						end
					end
					default: unsup_q <= 1'b1;
				endcase
			end
		end
	end

endmodule

FILE: design/ebc_ctrl.sv
// Sequencer that issues memory accesses and the execute command per action.
module ebc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	output logic               out_valid,
	input  logic               out_stall,
	input  ebc_pkg::ebc_stat_t stat,
	output ebc_pkg::ebc_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_F1    = 4'd1;
	localparam logic [3:0] S_F2    = 4'd2;
	localparam logic [3:0] S_DEC   = 4'd3;
	localparam logic [3:0] S_M1    = 4'd4;
	localparam logic [3:0] S_M2    = 4'd5;
	localparam logic [3:0] S_M3    = 4'd6;
	localparam logic [3:0] S_EXEC  = 4'd7;
	localparam logic [3:0] S_RD    = 4'd8;
	localparam logic [3:0] S_VEC1  = 4'd9;
	localparam logic [3:0] S_VEC2  = 4'd10;
	localparam logic [3:0] S_VEC3  = 4'd11;
	localparam logic [3:0] S_OUT   = 4'd12;

	logic [3:0] state_q, state_d;
	logic       accept;
	logic [7:0] op;

	assign op       = stat.opcode;
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.asel = ebc_pkg::AS_PC;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.start = 1'b1;
					unique case (action)
						ebc_pkg::ACT_STEP: begin
							cmd.rd = 1'b1; cmd.ld = ebc_pkg::LD_OP; state_d = S_F1;
						end
						ebc_pkg::ACT_LOAD: begin
							cmd.asel = ebc_pkg::AS_HOST; cmd.wr = 1'b1;
							cmd.wsel = ebc_pkg::WD_HOST; state_d = S_OUT;
						end
						ebc_pkg::ACT_READ: begin
							cmd.asel = ebc_pkg::AS_HOST; cmd.rd = 1'b1; state_d = S_RD;
						end
						default: begin
							cmd.asel = ebc_pkg::AS_VEC; cmd.rd = 1'b1;
							cmd.ld = ebc_pkg::LD_T0; state_d = S_VEC1;
						end
					endcase
				end
			end
			S_RD: begin cmd.capture_rd = 1'b1; state_d = S_OUT; end
			S_VEC1: begin
				cmd.asel = ebc_pkg::AS_VEC; cmd.rd = 1'b1; cmd.ld = ebc_pkg::LD_T1;
				state_d = S_VEC2;
			end
			S_VEC2: state_d = S_VEC3;
			S_VEC3: begin cmd.set_vec_pc = 1'b1; state_d = S_OUT; end
			S_F1: begin
				cmd.asel = ebc_pkg::AS_PC1; cmd.rd = 1'b1; cmd.ld = ebc_pkg::LD_B0;
				state_d = S_F2;
			end
			S_F2: begin
				cmd.asel = ebc_pkg::AS_PC2; cmd.rd = 1'b1; cmd.ld = ebc_pkg::LD_B1;
				state_d = S_DEC;
			end
			S_DEC: begin
				// b1 lands this cycle; operand-dependent accesses start next.
				state_d = S_M1;
			end
			S_M1: begin
				state_d = S_EXEC;
				unique case (op)
					ebc_pkg::OP_LDA_ABS, ebc_pkg::OP_BIT_ABS, ebc_pkg::OP_INC_ABS: begin
						cmd.asel = ebc_pkg::AS_ABS; cmd.rd = 1'b1;
						cmd.ld = ebc_pkg::LD_T0; state_d = S_M2;
					end
					ebc_pkg::OP_LDA_ABX: begin
						cmd.asel = ebc_pkg::AS_IDX; cmd.isel = ebc_pkg::IX_X;
						cmd.rd = 1'b1; cmd.ld = ebc_pkg::LD_T0; state_d = S_M2;
					end
					ebc_pkg::OP_STA_ZP, ebc_pkg::OP_STX_ZP: begin
						cmd.asel = ebc_pkg::AS_ZP; cmd.wr = 1'b1;
						cmd.wsel = (op == ebc_pkg::OP_STX_ZP) ? ebc_pkg::WD_X : ebc_pkg::WD_ACC;
					end
					ebc_pkg::OP_STA_ABS: begin
						cmd.asel = ebc_pkg::AS_ABS; cmd.wr = 1'b1; cmd.wsel = ebc_pkg::WD_ACC;
					end
					ebc_pkg::OP_STA_ABY: begin
						cmd.asel = ebc_pkg::AS_IDX; cmd.isel = ebc_pkg::IX_Y;
						cmd.wr = 1'b1; cmd.wsel = ebc_pkg::WD_ACC;
					end
					ebc_pkg::OP_STA_IZY: begin
						// Pointer low byte: address b0 in page zero.
						cmd.asel = ebc_pkg::AS_ZP; cmd.rd = 1'b1;
						cmd.ld = ebc_pkg::LD_T0; state_d = S_M2;
					end
					ebc_pkg::OP_JSR: begin
						cmd.asel = ebc_pkg::AS_STACK; cmd.wr = 1'b1;
						cmd.wsel = ebc_pkg::WD_PCH; cmd.sp = ebc_pkg::SP_DEC; state_d = S_M2;
					end
					ebc_pkg::OP_RTS: begin
						cmd.asel = ebc_pkg::AS_STACK; cmd.rd = 1'b1;
						cmd.sp = ebc_pkg::SP_INC; cmd.ld = ebc_pkg::LD_T0; state_d = S_M2;
					end
					default: state_d = S_EXEC;
				endcase
			end
			S_M2: begin
				state_d = S_EXEC;
				unique case (op)
					ebc_pkg::OP_INC_ABS: state_d = S_M3;
					ebc_pkg::OP_JSR: begin
						cmd.asel = ebc_pkg::AS_STACK; cmd.wr = 1'b1;
						cmd.wsel = ebc_pkg::WD_PCL; cmd.sp = ebc_pkg::SP_DEC;
					end
					ebc_pkg::OP_RTS: begin
						cmd.asel = ebc_pkg::AS_STACK; cmd.rd = 1'b1;
						cmd.sp = ebc_pkg::SP_INC; cmd.ld = ebc_pkg::LD_T1;
						state_d = S_M3;
					end
					ebc_pkg::OP_STA_IZY: begin
						// High pointer byte from b0+1 within page zero.
						cmd.asel = ebc_pkg::AS_ZP1; cmd.rd = 1'b1;
						cmd.ld = ebc_pkg::LD_T1; state_d = S_M3;
					end
					default: state_d = S_EXEC;
				endcase
			end
			S_M3: begin
				state_d = S_EXEC;
				unique case (op)
					ebc_pkg::OP_INC_ABS: begin
						cmd.asel = ebc_pkg::AS_ABS; cmd.wr = 1'b1; cmd.wsel = ebc_pkg::WD_INC;
					end
					default: ;
				endcase
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = S_OUT;
				// The full pointer is only available now, so the indirect store goes here.
				if (op == ebc_pkg::OP_STA_IZY) begin
					cmd.asel = ebc_pkg::AS_IDX; cmd.isel = ebc_pkg::IX_PTR;
					cmd.wr = 1'b1; cmd.wsel = ebc_pkg::WD_ACC;
				end
			end
			S_OUT: if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
